### rtl/mscs_pkg.sv
package mscs_pkg;

    // fixed field widths
    localparam int ELEMENT_WIDTH = 16;
    localparam int SUM_WIDTH     = 22;
    localparam int INDEX_WIDTH   = 6;
    localparam int CFG_WIDTH     = 7;

    // default matrix limits
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // stream packing: index, sum, element from bit 0 up, zero padded to bytes
    localparam int OUT_FIELDS_WIDTH = INDEX_WIDTH + SUM_WIDTH + ELEMENT_WIDTH;
    localparam int OUT_TDATA_WIDTH  = ((OUT_FIELDS_WIDTH + 7) / 8) * 8;
    localparam int OUT_PAD_WIDTH    = OUT_TDATA_WIDTH - OUT_FIELDS_WIDTH;

    // register port
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;
    localparam logic [CFG_WIDTH-1:0] CFG_RESET = CFG_WIDTH'(64);

    // register select, taken from paddr[2]
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    typedef enum logic [0:0] {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_EMIT_RD,
        S_EMIT_CAP,
        S_EMIT_WAIT
    } state_t;

endpackage

### rtl/mscs_ram.sv
module mscs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/mscs_alu.sv
module mscs_alu (
    input  mscs_pkg::alu_op_t              op,
    input  logic [mscs_pkg::SUM_WIDTH-1:0] a,
    input  logic [mscs_pkg::SUM_WIDTH-1:0] b,
    output logic [mscs_pkg::SUM_WIDTH-1:0] result,
    output logic                           less
);
    import mscs_pkg::*;

    logic [SUM_WIDTH:0] a_ext;
    logic [SUM_WIDTH:0] b_ext;
    logic [SUM_WIDTH:0] b_opd;
    logic [SUM_WIDTH:0] total;
    logic               sub;

    // one extra bit keeps the signed difference exact
    always_comb
    begin
        sub    = (op == ALU_SUB);
        a_ext  = {a[SUM_WIDTH-1], a};
        b_ext  = {b[SUM_WIDTH-1], b};
        b_opd  = sub ? ~b_ext : b_ext;
        total  = a_ext + b_opd + (SUM_WIDTH+1)'(sub);
        result = total[SUM_WIDTH-1:0];
        less   = total[SUM_WIDTH];
    end

endmodule

### rtl/min_sum_column_select_top.sv
// minimum column sum selection
// s_* channel: matrix elements in row-major order, one request per element.
// m_* channel: the elements of the column with the smallest sum, top to
// bottom, each tagged with the column index and its sum; m_tlast marks the
// bottom element. On a tie the lowest column index wins.
// APB port: register 0 (addr 0) row count, register 1 (addr 4) column count,
// 7 bits each, 0 acts as 1 and values above the limits act as the limit.
// Writing either register restarts the load at row 0, column 0.
// Each element is first accepted, then read-add-write of its column sum
// in the column sum memory via the shared adder.
// After the final element the scan reads each column in use from memory
// and then compares it in the same adder; each result then takes a matrix
// read, an output register load and a handshake, plus any receiver stall.
// s_tready is low from the final element until the last result is taken.
// While m_tready is low the result is held in the output register.
// Reset sets both counts to 64 and clears the load position; the matrix
// memory needs no clearing since only entries of the current load are read.
module min_sum_column_select_top #(
    parameter int MAX_ROWS = mscs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mscs_pkg::MAX_COLS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // element
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [mscs_pkg::ELEMENT_WIDTH-1:0]    s_tdata,
    // column_index, column_sum, column_element, zero pad
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [mscs_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata,
    output logic                                  m_tlast,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mscs_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [mscs_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [mscs_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                  pready
);
    import mscs_pkg::*;

    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;

    logic [CFG_WIDTH-1:0]     row_count_reg, column_count_reg;
    logic [RW-1:0]            rows_c;
    logic [CW-1:0]            cols_c;

    logic [RW-1:0]            row_reg, row_next;
    logic [CW-1:0]            col_reg, col_next;
    logic [MAW-1:0]           load_addr_reg, load_addr_next;
    logic [ELEMENT_WIDTH-1:0] elem_reg, elem_next;
    logic [CW-1:0]            scan_reg, scan_next;
    logic [SUM_WIDTH-1:0]     best_sum_reg, best_sum_next;
    logic [CIW-1:0]           best_col_reg, best_col_next;
    logic [RW-1:0]            erow_reg, erow_next;
    logic [MAW-1:0]           emit_addr_reg, emit_addr_next;
    logic [ELEMENT_WIDTH-1:0] out_elem_reg, out_elem_next;
    logic                     out_last_reg, out_last_next;

    logic                     cfg_we;
    logic                     in_req;
    logic                     out_req;
    logic                     col_wrap;
    logic                     row_wrap;
    logic                     scan_more;
    logic                     take_new;
    logic [CIW-1:0]           scan_idx;

    // control from the sequencer
    alu_op_t                  alu_op;
    logic [SUM_WIDTH-1:0]     alu_a, alu_b, alu_result;
    logic                     alu_less;
    logic                     sum_we;
    logic [CIW-1:0]           sum_raddr;
    logic [SUM_WIDTH-1:0]     sum_rdata;
    logic                     mat_we;
    logic [MAW-1:0]           mat_raddr;
    logic [ELEMENT_WIDTH-1:0] mat_rdata;
    logic [SUM_WIDTH-1:0]     elem_ext;

    // register port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= CFG_RESET;
            column_count_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (paddr[2])
                REG_ROW_COUNT:    row_count_reg    <= pwdata[CFG_WIDTH-1:0];
                REG_COLUMN_COUNT: column_count_reg <= pwdata[CFG_WIDTH-1:0];
                default:          row_count_reg    <= row_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ROW_COUNT:    prdata = APB_DATA_WIDTH'(row_count_reg);
            REG_COLUMN_COUNT: prdata = APB_DATA_WIDTH'(column_count_reg);
            default:          prdata = '0;
        endcase
    end

    // counts in use, clamped to 1..limit
    always_comb
    begin
        if (row_count_reg == '0)
            rows_c = RW'(1);
        else if (int'(row_count_reg) > MAX_ROWS)
            rows_c = RW'(MAX_ROWS);
        else
            rows_c = RW'(row_count_reg);

        if (column_count_reg == '0)
            cols_c = CW'(1);
        else if (int'(column_count_reg) > MAX_COLS)
            cols_c = CW'(MAX_COLS);
        else
            cols_c = CW'(column_count_reg);
    end

    // handshakes and position tests
    assign in_req    = s_tvalid && s_tready;
    assign out_req   = m_tvalid && m_tready;
    assign col_wrap  = (col_reg + CW'(1)) >= cols_c;
    assign row_wrap  = (row_reg + RW'(1)) >= rows_c;
    assign scan_more = (scan_reg + CW'(1)) < cols_c;
    assign scan_idx  = scan_reg[CIW-1:0];
    assign take_new  = (scan_reg == '0) || alu_less;
    assign elem_ext  = {{(SUM_WIDTH-ELEMENT_WIDTH){elem_reg[ELEMENT_WIDTH-1]}}, elem_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_tvalid)
                    state_next = S_ACC;
            S_ACC:
                if (col_wrap && row_wrap)
                    state_next = S_SCAN_RD;
                else
                    state_next = S_IDLE;
            S_SCAN_RD:
                state_next = S_SCAN_CMP;
            S_SCAN_CMP:
                if (scan_more)
                    state_next = S_SCAN_RD;
                else
                    state_next = S_EMIT_RD;
            S_EMIT_RD:
                state_next = S_EMIT_CAP;
            S_EMIT_CAP:
                state_next = S_EMIT_WAIT;
            S_EMIT_WAIT:
                if (m_tready)
                    state_next = out_last_reg ? S_IDLE : S_EMIT_RD;
            default:
                state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        mat_we    = 1'b0;
        sum_we    = 1'b0;
        alu_op    = ALU_ADD;
        alu_a     = sum_rdata;
        alu_b     = elem_ext;
        sum_raddr = col_reg[CIW-1:0];
        mat_raddr = emit_addr_reg;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                mat_we   = in_req;
            end
            S_ACC:
            begin
                // first row starts the column sum from zero
                sum_we = 1'b1;
                if (row_reg == '0)
                    alu_a = '0;
            end
            S_SCAN_RD:
                sum_raddr = scan_idx;
            S_SCAN_CMP:
            begin
                alu_op = ALU_SUB;
                alu_b  = best_sum_reg;
            end
            S_EMIT_WAIT:
                m_tvalid = 1'b1;
            default:
                s_tready = 1'b0;
        endcase
    end

    // datapath next values
    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        load_addr_next = load_addr_reg;
        elem_next      = elem_reg;
        scan_next      = scan_reg;
        best_sum_next  = best_sum_reg;
        best_col_next  = best_col_reg;
        erow_next      = erow_reg;
        emit_addr_next = emit_addr_reg;
        out_elem_next  = out_elem_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            S_IDLE:
                if (in_req)
                    elem_next = s_tdata;
            S_ACC:
            begin
                load_addr_next = load_addr_reg + MAW'(1);
                if (!col_wrap)
                    col_next = col_reg + CW'(1);
                else
                begin
                    col_next = '0;
                    if (!row_wrap)
                        row_next = row_reg + RW'(1);
                    else
                    begin
                        row_next       = '0;
                        load_addr_next = '0;
                        scan_next      = '0;
                    end
                end
            end
            S_SCAN_CMP:
            begin
                if (take_new)
                begin
                    best_sum_next = sum_rdata;
                    best_col_next = scan_idx;
                end
                if (scan_more)
                    scan_next = scan_reg + CW'(1);
                else
                begin
                    erow_next      = '0;
                    emit_addr_next = MAW'(take_new ? scan_idx : best_col_reg);
                end
            end
            S_EMIT_CAP:
            begin
                out_elem_next = mat_rdata;
                out_last_next = (erow_reg + RW'(1)) >= rows_c;
            end
            S_EMIT_WAIT:
                if (out_req && !out_last_reg)
                begin
                    erow_next      = erow_reg + RW'(1);
                    emit_addr_next = emit_addr_reg + MAW'(cols_c);
                end
            default:
                elem_next = elem_reg;
        endcase

        // a register write restarts the load
        if (cfg_we)
        begin
            row_next       = '0;
            col_next       = '0;
            load_addr_next = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            load_addr_reg <= '0;
            scan_reg      <= '0;
            erow_reg      <= '0;
            emit_addr_reg <= '0;
            out_last_reg  <= 1'b0;
            best_sum_reg  <= '0;
            best_col_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            load_addr_reg <= load_addr_next;
            scan_reg      <= scan_next;
            erow_reg      <= erow_next;
            emit_addr_reg <= emit_addr_next;
            out_last_reg  <= out_last_next;
            best_sum_reg  <= best_sum_next;
            best_col_reg  <= best_col_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        elem_reg     <= elem_next;
        out_elem_reg <= out_elem_next;
    end

    // shared adder and comparator
    mscs_alu u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_result),
        .less   (alu_less)
    );

    // running column sums
    mscs_ram #(
        .WIDTH (SUM_WIDTH),
        .DEPTH (MAX_COLS),
        .AW    (CIW)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (col_reg[CIW-1:0]),
        .wdata (alu_result),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    // matrix store, packed at row * columns in use + column
    mscs_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (DEPTH),
        .AW    (MAW)
    ) u_mat_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr (load_addr_reg),
        .wdata (s_tdata),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    // result stream
    assign m_tdata = {{OUT_PAD_WIDTH{1'b0}}, out_elem_reg, best_sum_reg,
                      INDEX_WIDTH'(best_col_reg)};
    assign m_tlast = out_last_reg;

endmodule

### rtl/mscs_checker.sv
module mscs_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [mscs_pkg::OUT_TDATA_WIDTH-1:0] m_tdata,
    input logic                                 m_tlast
);

    // no element taken while a result is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("element accepted while result pending");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed under stall");

    // column ends after the marked element
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result after last element");

    // mid-column no new elements are taken
    a_mid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !s_tready)
        else $error("input opened before column finished");

endmodule

bind min_sum_column_select_top mscs_checker u_mscs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
